// ----- rtl/pfr_pkg.sv -----
// shared constants, widths and types of the page framebuffer refresh block
package pfr_pkg;

  localparam int COLUMNS   = 128;
  localparam int PAGES     = 8;
  localparam int ROWS      = PAGES * 8;
  localparam int SEG_LEN   = COLUMNS + 3;
  localparam int DEPTH     = COLUMNS * PAGES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int OFF_W     = $clog2(SEG_LEN);
  localparam int CMD_BYTES = 3;

  // action codes carried in tuser
  localparam logic [1:0] ACT_DRAW    = 2'd0;
  localparam logic [1:0] ACT_CLEAR   = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;

  // panel commands that open each page
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  // current refresh position as seen by the controller
  typedef struct packed {
    logic              is_data;
    logic              frame_end;
    logic [7:0]        cmd_byte;
    logic [ADDR_W-1:0] addr;
  } seq_t;

endpackage

// ----- rtl/page_framebuffer_refresh.sv -----
// top level of the page framebuffer with refresh byte sequencer
//
//  channel  dir  tdata                               tuser          tlast
//  s_axis   in   [7:0] x, [15:8] y, [16] on          [1:0] action   -
//  m_axis   out  [7:0] out_byte                      [0] is_data    frame_end
//
// a draw reads the store, then writes the modified byte back
// a refresh beat is a store read (or command pick), then the output register
// a clear sweeps the store one byte a cycle, all 1024 bytes (COLUMNS*PAGES), no beat taken
// the same clearing pass runs after reset
// input waits while the output register holds a beat that is not taken
module page_framebuffer_refresh (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] pixel_on
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] is_data
  output logic        m_axis_tlast    // frame_end
);

  localparam logic [1:0] ST_CLEAR   = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_DRAW    = 2'd2;
  localparam logic [1:0] ST_REFRESH = 2'd3;

  logic [1:0] state_q, state_d;

  // input fields
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_on;
  logic [1:0] action;
  logic       in_beat;

  assign pixel_x  = s_axis_tdata[7:0];
  assign pixel_y  = s_axis_tdata[15:8];
  assign pixel_on = s_axis_tdata[16];
  assign action   = s_axis_tuser;

  // accept only when idle and the output register is free or draining
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // draw decode: off-panel pixels are dropped
  logic                        on_panel;
  logic [4:0]                  page_full;
  logic [pfr_pkg::ADDR_W-1:0]  draw_addr;
  logic [7:0]                  draw_mask;
  logic                        draw_go;
  logic                        clear_go;
  logic                        refresh_go;

  assign on_panel  = ({1'b0, pixel_x} < 9'(pfr_pkg::COLUMNS))
                  && ({1'b0, pixel_y} < 9'(pfr_pkg::ROWS));
  // rows count upward from the bottom page
  assign page_full = 5'(5'(pfr_pkg::PAGES - 1) - pixel_y[7:3]);
  assign draw_addr = pfr_pkg::ADDR_W'(
                       pfr_pkg::ADDR_W'(pfr_pkg::COL_W'(pixel_x))
                       * pfr_pkg::ADDR_W'(pfr_pkg::PAGES)
                       + pfr_pkg::ADDR_W'(pfr_pkg::PAGE_W'(page_full)));
  assign draw_mask = 8'(8'h80 >> pixel_y[2:0]);

  assign draw_go    = in_beat && (action == pfr_pkg::ACT_DRAW) && on_panel;
  assign clear_go   = in_beat && (action == pfr_pkg::ACT_CLEAR);
  assign refresh_go = in_beat && (action == pfr_pkg::ACT_REFRESH);

  // refresh position
  pfr_pkg::seq_t seq;

  pfr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (refresh_go),
    .seq_o     (seq)
  );

  // clearing sweep pointer
  logic [pfr_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic                       clr_done;

  assign clr_done = (clr_addr_q == pfr_pkg::ADDR_W'(pfr_pkg::DEPTH - 1));

  // pending draw and refresh beat info, payload only
  logic [pfr_pkg::ADDR_W-1:0] wr_addr_q;
  logic [7:0]                 wr_mask_q;
  logic                       wr_on_q;
  logic                       rf_data_q;
  logic                       rf_last_q;
  logic [7:0]                 rf_cmd_q;

  always_ff @(posedge clk_i) begin
    if (draw_go) begin
      wr_addr_q <= draw_addr;
      wr_mask_q <= draw_mask;
      wr_on_q   <= pixel_on;
    end
    if (refresh_go) begin
      rf_data_q <= seq.is_data;
      rf_last_q <= seq.frame_end;
      rf_cmd_q  <= seq.cmd_byte;
    end
  end

  // store port control
  logic                       ram_we;
  logic [pfr_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [pfr_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = wr_on_q ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q);
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = 8'h00;
    end else if (state_q == ST_DRAW) begin
      ram_we = 1'b1;
    end
  end

  // one read per item: the pixel byte for a draw, the column byte for refresh data
  assign ram_re    = draw_go || (refresh_go && seq.is_data);
  assign ram_raddr = draw_go ? draw_addr : seq.addr;

  pfr_ram #(
    .DEPTH (pfr_pkg::DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // controller
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = pfr_pkg::ADDR_W'(clr_addr_q + 1'b1);
        if (clr_done) begin
          state_d    = ST_IDLE;
          clr_addr_d = '0;
        end
      end
      ST_IDLE: begin
        if (draw_go) begin
          state_d = ST_DRAW;
        end else if (clear_go) begin
          state_d    = ST_CLEAR;
          clr_addr_d = '0;
        end else if (refresh_go) begin
          state_d = ST_REFRESH;
        end
      end
      ST_DRAW:    state_d = ST_IDLE;
      ST_REFRESH: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // output register
  logic       m_valid_q;
  logic [7:0] m_byte_q;
  logic       m_data_q;
  logic       m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_REFRESH) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_REFRESH) begin
      m_byte_q <= rf_data_q ? ram_rdata : rf_cmd_q;
      m_data_q <= rf_data_q;
      m_last_q <= rf_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // a new output beat only comes out of the refresh step
  a_beat_from_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_REFRESH)
    else $error("output beat without refresh step");

  // no input taken while the clearing sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("input accepted during clear");

  // the frame always closes on a data byte
  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end on a command byte");

  // a refresh beat goes straight to the refresh step
  a_refresh_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refresh_go |=> state_q == ST_REFRESH && !m_axis_tvalid)
    else $error("refresh beat not followed by refresh step");

endmodule

// ----- rtl/pfr_ram.sv -----
// generic simple dual-port ram with registered read data
module pfr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pfr_seq.sv -----
// refresh position counter: page and offset within the page segment
module pfr_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  output pfr_pkg::seq_t seq_o
);

  logic [pfr_pkg::PAGE_W-1:0] page_q, page_d;
  logic [pfr_pkg::OFF_W-1:0]  off_q, off_d;
  logic                       seg_end;
  logic                       last_page;
  logic [pfr_pkg::COL_W-1:0]  col;

  assign seg_end   = (off_q == pfr_pkg::OFF_W'(pfr_pkg::SEG_LEN - 1));
  assign last_page = (page_q == pfr_pkg::PAGE_W'(pfr_pkg::PAGES - 1));
  assign col       = pfr_pkg::COL_W'(off_q - pfr_pkg::OFF_W'(pfr_pkg::CMD_BYTES));

  always_comb begin
    page_d = page_q;
    off_d  = off_q;
    if (advance_i) begin
      if (seg_end) begin
        off_d  = '0;
        page_d = last_page ? '0 : pfr_pkg::PAGE_W'(page_q + 1'b1);
      end else begin
        off_d = pfr_pkg::OFF_W'(off_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      off_q  <= '0;
    end else begin
      page_q <= page_d;
      off_q  <= off_d;
    end
  end

  always_comb begin
    seq_o.is_data   = (off_q >= pfr_pkg::OFF_W'(pfr_pkg::CMD_BYTES));
    seq_o.frame_end = seg_end && last_page;
    seq_o.addr      = pfr_pkg::ADDR_W'(pfr_pkg::ADDR_W'(col) * pfr_pkg::ADDR_W'(pfr_pkg::PAGES)
                      + pfr_pkg::ADDR_W'(page_q));
    case (off_q)
      pfr_pkg::OFF_W'(0): seq_o.cmd_byte = 8'(pfr_pkg::CMD_PAGE_BASE + 8'(page_q));
      pfr_pkg::OFF_W'(1): seq_o.cmd_byte = pfr_pkg::CMD_COL_LO;
      pfr_pkg::OFF_W'(2): seq_o.cmd_byte = pfr_pkg::CMD_COL_HI;
      default:            seq_o.cmd_byte = 8'h00;
    endcase
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the page framebuffer refresh block
module tb_top;

  // one refresh frame: every page opens with three commands, then one data byte per column
  localparam int FRAME_LEN = pfr_pkg::PAGES * pfr_pkg::SEG_LEN;
  // watchdog limit, several times the slowest legal run
  localparam int RUN_LIMIT = 2000000 * 12;
  // quiet time at the end, longer than one full clearing sweep
  localparam int TAIL_CYCLES = pfr_pkg::DEPTH + 100;
  localparam int RANDOM_OPS = 900;
  // spare action code, ignored by the block
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // one input beat as the block sees it, plus a flag that holds it back
  // until every expected refresh byte has come out
  typedef struct {
    logic [1:0] action;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
    logic       hold;
  } panel_op_t;

  // one refresh beat on the output side
  typedef struct {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } refresh_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] pixel_x, [15:8] pixel_y, [16] pixel_on
  logic [1:0]  s_axis_tuser = '0;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic        m_axis_tuser;        // [0] is_data
  logic        m_axis_tlast;        // frame_end

  // shadow copy of the frame store and the refresh counter
  logic [7:0]  shadow_fb [0:pfr_pkg::DEPTH-1];
  int unsigned shadow_pos;

  panel_op_t     pending_ops[$];
  refresh_beat_t expected_bytes[$];
  panel_op_t     cur_op;

  int unsigned ops_queued;
  int unsigned ops_taken;
  int unsigned gen_refreshes;
  int unsigned mismatch_count;

  int  send_gap;
  int  recv_stall;
  bit  send_calm;
  bit  recv_calm;
  bit  drv_vld;

  page_framebuffer_refresh dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // advance the shadow state by one accepted beat, queue the refresh byte it causes
  task automatic apply_panel_op(input panel_op_t op);
    int unsigned   col;
    int unsigned   row;
    int unsigned   page;
    int unsigned   off;
    refresh_beat_t beat;
    col = op.x;
    row = op.y;
    case (op.action)
      pfr_pkg::ACT_DRAW: begin
        // pixels off the panel leave the store alone
        if (col < pfr_pkg::COLUMNS && row < pfr_pkg::ROWS) begin
          page = pfr_pkg::PAGES - 1 - row / 8;
          shadow_fb[col * pfr_pkg::PAGES + page][7 - row % 8] = op.on;
        end
      end
      pfr_pkg::ACT_CLEAR: begin
        // clearing keeps the refresh position
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
      end
      pfr_pkg::ACT_REFRESH: begin
        page = shadow_pos / pfr_pkg::SEG_LEN;
        off  = shadow_pos % pfr_pkg::SEG_LEN;
        if (off < pfr_pkg::CMD_BYTES) begin
          // page address, then low and high column start
          beat.is_data = 1'b0;
          if (off == 0) beat.out_byte = 8'(pfr_pkg::CMD_PAGE_BASE + page);
          else if (off == 1) beat.out_byte = pfr_pkg::CMD_COL_LO;
          else beat.out_byte = pfr_pkg::CMD_COL_HI;
        end else begin
          beat.is_data  = 1'b1;
          beat.out_byte = shadow_fb[(off - pfr_pkg::CMD_BYTES) * pfr_pkg::PAGES + page];
        end
        beat.frame_end = (shadow_pos == FRAME_LEN - 1);
        // wrap to page 0 after the last byte of a frame
        shadow_pos = beat.frame_end ? 0 : shadow_pos + 1;
        expected_bytes.push_back(beat);
      end
      default: begin
        // the spare action code does nothing
      end
    endcase
  endtask

  task automatic queue_op(input logic [1:0] action, input logic [7:0] x, input logic [7:0] y,
                          input logic on, input logic hold);
    panel_op_t op;
    op.action = action;
    op.x      = x;
    op.y      = y;
    op.on     = on;
    op.hold   = hold;
    pending_ops.push_back(op);
    ops_queued++;
    if (action == pfr_pkg::ACT_REFRESH) gen_refreshes++;
  endtask

  // random draw, mostly on the panel, sometimes just past its edges or far off
  task automatic queue_random_draw(input logic hold);
    logic [7:0] x;
    logic [7:0] y;
    x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(pfr_pkg::COLUMNS, 255))
                                    : 8'($urandom_range(0, pfr_pkg::COLUMNS - 1));
    y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(pfr_pkg::ROWS, 255))
                                    : 8'($urandom_range(0, pfr_pkg::ROWS - 1));
    queue_op(pfr_pkg::ACT_DRAW, x, y, 1'($urandom_range(0, 3) != 0), hold);
  endtask

  // driver: presents queued beats, with gaps of random length between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      drv_vld   = 1'b0;
      send_gap  = 0;
      send_calm = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_panel_op(cur_op);
        ops_taken++;
        drv_vld = 1'b0;
      end
      if (!drv_vld) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].hold && expected_bytes.size() != 0)) begin
          cur_op  = pending_ops.pop_front();
          drv_vld = 1'b1;
          // stretches without any idling now and then
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : pick_gap();
        end
      end
      s_axis_tvalid <= drv_vld;
      s_axis_tdata  <= {7'b0, cur_op.on, cur_op.y, cur_op.x};
      s_axis_tuser  <= cur_op.action;
    end
  end

  // monitor: random back pressure, every taken beat checked against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    refresh_beat_t want;
    bit            rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
      recv_calm  = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected refresh beat: byte %02h data %0b last %0b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.out_byte || m_axis_tuser !== want.is_data ||
              m_axis_tlast !== want.frame_end) begin
            if (mismatch_count < 10)
              $display({"refresh beat mismatch: exp byte %02h data %0b last %0b, ",
                        "got byte %02h data %0b last %0b"},
                       want.out_byte, want.is_data, want.frame_end,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if ($urandom_range(0, 255) == 0) recv_calm = !recv_calm;
        if (!recv_calm && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
      m_axis_tready <= rdy;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned random_ops;
    int unsigned burst;
    int unsigned kind;
    bit          hold_next;

    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    shadow_pos     = 0;
    ops_queued     = 0;
    ops_taken      = 0;
    gen_refreshes  = 0;
    mismatch_count = 0;

    // directed part: panel corners, off-panel coordinates, set then clear,
    // spare action code, clear in the middle of a frame
    queue_op(pfr_pkg::ACT_DRAW, 8'd0,   8'd0,   1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd127, 8'd63,  1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd0,   8'd63,  1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd127, 8'd0,   1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd128, 8'd5,   1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd3,   8'd64,  1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd255, 8'd255, 1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd1,   8'd7,   1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd1,   8'd56,  1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd2,   8'd17,  1'b1, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW, 8'd2,   8'd17,  1'b0, 1'b0);
    queue_op(ACT_SPARE,         8'd255, 8'd255, 1'b1, 1'b0);
    repeat (6) queue_op(pfr_pkg::ACT_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);
    queue_op(pfr_pkg::ACT_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0);
    queue_op(pfr_pkg::ACT_DRAW,  8'd1, 8'd63, 1'b1, 1'b0);
    repeat (3) queue_op(pfr_pkg::ACT_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0);

    // random part: bursts of refresh bytes and of draws, rare clears, some noise;
    // the first burst waits for an empty pipeline
    random_ops = 0;
    hold_next  = 1'b1;
    while (random_ops < RANDOM_OPS) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        burst = $urandom_range(10, 150);
        repeat (burst) begin
          queue_op(pfr_pkg::ACT_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom),
                   hold_next);
          hold_next = 1'b0;
        end
        random_ops += burst;
      end else if (kind < 95) begin
        burst = $urandom_range(1, 30);
        repeat (burst) begin
          queue_random_draw(hold_next);
          hold_next = 1'b0;
        end
        random_ops += burst;
      end else if (kind < 97) begin
        queue_op(pfr_pkg::ACT_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), hold_next);
        hold_next = 1'b0;
        random_ops++;
      end else begin
        // ignored beats, not counted
        repeat ($urandom_range(1, 3))
          queue_op(ACT_SPARE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
    end

    // run the refresh past a frame end and a few bytes into the next frame
    while (gen_refreshes < FRAME_LEN + 5) begin
      if ($urandom_range(0, 15) == 0) queue_random_draw(1'b0);
      else queue_op(pfr_pkg::ACT_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sample away from the active edge
    while (ops_taken != ops_queued || expected_bytes.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("PASS page_framebuffer_refresh");
    end else begin
      $display("FAIL page_framebuffer_refresh");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("FAIL page_framebuffer_refresh");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pfr_pkg.sv
rtl/pfr_ram.sv
rtl/pfr_seq.sv
rtl/page_framebuffer_refresh.sv
tb/sv/tb_top.sv
